>>> rtl/pointer_hash_set_linear_probe_top_defines.svh
// Assertion macros for the pointer hash set RTL.
// No dependencies; files that check their own logic include this header.
`ifndef POINTER_HASH_SET_LINEAR_PROBE_TOP_DEFINES_SVH
`define POINTER_HASH_SET_LINEAR_PROBE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/phs_pkg.sv
// Shared types and codes for the pointer hash set.
// No dependencies.
package phs_pkg;

   localparam int REQ_W    = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int COUNT_W  = 10;
   localparam int SLOT_ST_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_NULL_KEY  = 3'd6;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd7;

   // slot states
   localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY = 2'd0;
   localparam logic [SLOT_ST_W-1:0] SLOT_LIVE  = 2'd1;
   localparam logic [SLOT_ST_W-1:0] SLOT_TOMB  = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [COUNT_W-1:0]  live_count;
   } rsp_item_type;

endpackage

>>> rtl/phs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/phs_mod_unit.sv
// Iterative key modulo table size: eight conditional-subtract steps per cycle.
// No dependencies.
module phs_mod_unit #(
   parameter int TABLE_SIZE = 1021,
   parameter int KEY_WIDTH  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_WIDTH-1:0]          key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] rem
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int RW    = IDX_W + 1;
   localparam int DIG   = 8;
   localparam int STEPS = (KEY_WIDTH + DIG - 1) / DIG;
   localparam int PAD_W = STEPS * DIG;
   localparam int SCW   = $clog2(STEPS + 1);
   localparam logic [RW-1:0]  MODULUS   = RW'(TABLE_SIZE);
   localparam logic [SCW-1:0] LAST_STEP = SCW'(STEPS - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SCW-1:0]   step_ff, step_in;
   logic [PAD_W-1:0] sr_ff, sr_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [RW-1:0]    acc;

   // remainder update: r = (2r + bit) mod N, MSB first, DIG bits a cycle
   always_comb begin
      logic [RW-1:0] t;
      acc = RW'(rem_ff);
      for (int i = 0; i < DIG; i++) begin
         t = {acc[RW-2:0], sr_ff[PAD_W-1-i]};
         if (t >= MODULUS) begin
            t = t - MODULUS;
         end
         acc = t;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sr_in   = sr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         sr_in   = PAD_W'(key);
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = acc[IDX_W-1:0];
         sr_in   = sr_ff << DIG;
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      sr_ff   <= sr_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

>>> rtl/pointer_hash_set_linear_probe_top.sv
// Pointer hash set: open addressing, linear probing, tombstones.
// Accepted items pass S_HASH (modulo unit), S_PROBE (one slot a cycle, 1..TABLE_SIZE
// slots) and S_DONE, which registers the result once the output is free. Null key or
// full insert skip to S_DONE; clear sweeps every slot first. One item at a time.
// After reset a clearing pass over all slots empties slot state; req_stall is high.
`include "pointer_hash_set_linear_probe_top_defines.svh"

module pointer_hash_set_linear_probe_top #(
   parameter int TABLE_SIZE = 1021,
   parameter int KEY_WIDTH  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  phs_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output phs_pkg::rsp_item_type rsp_data
);
   import phs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE - 2);

   typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_DONE, S_CLEAR} state_type;
   typedef enum logic [1:0] {K_PROBE, K_NULL, K_FULL, K_CLEAR} kind_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [REQ_W-1:0]   req_code_ff, req_code_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_pos_ff, hit_pos_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_pos_ff, free_pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   clr_pos_ff, clr_pos_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic               mod_start, mod_done;
   logic [IDX_W-1:0]   mod_rem;
   logic [IDX_W-1:0]   pos_next, rd_addr, wr_addr;
   logic               wr_st_en, wr_key_en;
   logic [SLOT_ST_W-1:0] wr_st_data, st_rd;
   logic [KEY_WIDTH-1:0] key_rd;
   logic               key_null, pr_live, pr_empty, pr_match;

   phs_mod_unit #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (req_data.key[KEY_WIDTH-1:0]),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   phs_ram #(
      .WIDTH (SLOT_ST_W),
      .DEPTH (TABLE_SIZE)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (wr_st_en),
      .wr_addr (wr_addr),
      .wr_data (wr_st_data),
      .rd_addr (rd_addr),
      .rd_data (st_rd)
   );

   phs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (TABLE_SIZE)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_key_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   assign key_null = (req_data.key[KEY_WIDTH-1:0] == '0);
   assign pos_next = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
   // home slot is read as the hash finishes; after that the next slot is read ahead
   assign rd_addr  = (state_ff == S_HASH) ? mod_rem : pos_next;
   assign pr_live  = (st_rd == SLOT_LIVE);
   assign pr_empty = (st_rd == SLOT_EMPTY);
   assign pr_match = pr_live && (key_rd == key_ff);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      req_code_in  = req_code_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      free_in      = free_ff;
      free_pos_in  = free_pos_ff;
      cnt_in       = cnt_ff;
      clr_pos_in   = clr_pos_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mod_start    = 1'b0;
      wr_st_en     = 1'b0;
      wr_key_en    = 1'b0;
      wr_addr      = free_pos_ff;
      wr_st_data   = SLOT_EMPTY;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_code_in = req_data.req_type;
               key_in      = req_data.key[KEY_WIDTH-1:0];
               hit_in      = 1'b0;
               free_in     = 1'b0;
               n_in        = '0;
               if (req_data.req_type == REQ_CLEAR) begin
                  kind_in    = K_CLEAR;
                  clr_pos_in = '0;
                  clr_rsp_in = 1'b1;
                  cnt_in     = '0;
                  state_in   = S_CLEAR;
               end else if (key_null) begin
                  kind_in  = K_NULL;
                  state_in = S_DONE;
               end else if (req_data.req_type == REQ_INSERT && cnt_ff >= CNT_FULL) begin
                  kind_in  = K_FULL;
                  state_in = S_DONE;
               end else begin
                  kind_in   = K_PROBE;
                  mod_start = 1'b1;
                  state_in  = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               pos_in   = mod_rem;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (!pr_live && !free_ff) begin
               free_in     = 1'b1;
               free_pos_in = pos_ff;
            end
            if (pr_match) begin
               hit_in     = 1'b1;
               hit_pos_in = pos_ff;
            end
            if (pr_match || pr_empty || n_ff == LAST_IDX) begin
               state_in = S_DONE;
            end
            pos_in = pos_next;
            n_in   = n_ff + 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.slot_index = '0;
               state_in               = S_IDLE;
               unique case (kind_ff)
                  K_NULL:  rsp_data_in.status = STATUS_NULL_KEY;
                  K_FULL:  rsp_data_in.status = STATUS_FULL;
                  K_CLEAR: rsp_data_in.status = STATUS_CLEARED;
                  K_PROBE: begin
                     unique case (req_code_ff)
                        REQ_INSERT: begin
                           if (hit_ff) begin
                              rsp_data_in.status     = STATUS_PRESENT;
                              rsp_data_in.slot_index = SLOT_W'(hit_pos_ff);
                           end else if (free_ff) begin
                              wr_st_en               = 1'b1;
                              wr_key_en              = 1'b1;
                              wr_addr                = free_pos_ff;
                              wr_st_data             = SLOT_LIVE;
                              cnt_in                 = cnt_ff + 1'b1;
                              rsp_data_in.status     = STATUS_INSERTED;
                              rsp_data_in.slot_index = SLOT_W'(free_pos_ff);
                           end else begin
                              rsp_data_in.status = STATUS_FULL;
                           end
                        end
                        REQ_LOOKUP: begin
                           if (hit_ff) begin
                              rsp_data_in.status     = STATUS_FOUND;
                              rsp_data_in.slot_index = SLOT_W'(hit_pos_ff);
                           end else begin
                              rsp_data_in.status = STATUS_NOT_FOUND;
                           end
                        end
                        default: begin
                           if (hit_ff) begin
                              wr_st_en   = 1'b1;
                              wr_addr    = hit_pos_ff;
                              wr_st_data = SLOT_TOMB;
                              if (cnt_ff != '0) begin
                                 cnt_in = cnt_ff - 1'b1;
                              end
                              rsp_data_in.status     = STATUS_REMOVED;
                              rsp_data_in.slot_index = SLOT_W'(hit_pos_ff);
                           end else begin
                              rsp_data_in.status = STATUS_NOT_FOUND;
                           end
                        end
                     endcase
                  end
                  default: rsp_data_in.status = STATUS_NULL_KEY;
               endcase
               rsp_data_in.live_count = COUNT_W'(cnt_in);
            end
         end
         S_CLEAR: begin
            wr_st_en   = 1'b1;
            wr_addr    = clr_pos_ff;
            wr_st_data = SLOT_EMPTY;
            if (clr_pos_ff == LAST_IDX) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               clr_pos_in = clr_pos_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         kind_ff      <= K_CLEAR;
         clr_pos_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         clr_pos_ff   <= clr_pos_in;
         clr_rsp_ff   <= clr_rsp_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_code_ff <= req_code_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      n_ff        <= n_in;
      hit_pos_ff  <= hit_pos_in;
      free_pos_ff <= free_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PHS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL, "live count above table limit")
   `PHS_ASSERT_NOW(a_write_state, clock, reset, wr_st_en, state_ff == S_DONE || state_ff == S_CLEAR, "slot write outside result or clear")
   `PHS_ASSERT_NOW(a_hash_state, clock, reset, mod_done, state_ff == S_HASH, "modulo result outside hash state")
   `PHS_ASSERT_NOW(a_clear_count, clock, reset, state_ff == S_CLEAR, cnt_ff == '0, "count not zero while clearing")
   `PHS_ASSERT_NEXT(a_clear_entry, clock, reset, state_ff == S_IDLE && req_valid && req_data.req_type == REQ_CLEAR, state_ff == S_CLEAR, "clear item did not start sweep")

endmodule

>>> bench/hash_set_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pointer hash set: watches both item channels, keeps its own copy of
// the slot table, predicts every result and compares it field by field. Depends on phs_pkg.
module hash_set_checker #(
   parameter int TABLE_SIZE = 1021,
   parameter int KEY_WIDTH  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  phs_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  phs_pkg::rsp_item_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import phs_pkg::*;

   localparam logic [KEY_W-1:0] KEY_MASK     = {KEY_W{1'b1}} >> (KEY_W - KEY_WIDTH);
   localparam logic [KEY_W-1:0] TABLE_SIZE_K = KEY_W'(TABLE_SIZE);

   logic [KEY_W-1:0]     slot_key_m   [TABLE_SIZE];
   logic [SLOT_ST_W-1:0] slot_state_m [TABLE_SIZE];
   int unsigned          live_keys;
   rsp_item_type         awaited_rsp [$];

   // Applies one request to the shadow table and returns the answer it must produce.
   function automatic rsp_item_type apply_request(req_item_type item);
      rsp_item_type     ans;
      logic [KEY_W-1:0] k;
      int               pos;
      int               hit;
      int               free_at;
      bit               done;
      ans     = '0;
      k       = item.key & KEY_MASK;
      hit     = -1;
      free_at = -1;
      if (item.req_type == REQ_CLEAR) begin
         foreach (slot_state_m[i]) slot_state_m[i] = SLOT_EMPTY;
         live_keys  = 0;
         ans.status = STATUS_CLEARED;
      end else if (k == '0) begin
         ans.status = STATUS_NULL_KEY;
      end else if (item.req_type == REQ_INSERT && live_keys + 2 >= TABLE_SIZE) begin
         // refused even when the key is already there
         ans.status = STATUS_FULL;
      end else begin
         // circular walk from the home slot; tombstones are passed, an empty slot ends a miss
         pos  = int'(k % TABLE_SIZE_K);
         done = 1'b0;
         for (int n = 0; n < TABLE_SIZE && !done; n++) begin
            if (slot_state_m[pos] == SLOT_LIVE) begin
               if (slot_key_m[pos] == k) begin
                  hit  = pos;
                  done = 1'b1;
               end
            end else begin
               if (free_at < 0) free_at = pos;
               if (slot_state_m[pos] == SLOT_EMPTY) done = 1'b1;
            end
            pos = (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
         end
         case (item.req_type)
            REQ_INSERT: begin
               if (hit >= 0) begin
                  ans.status     = STATUS_PRESENT;
                  ans.slot_index = hit[SLOT_W-1:0];
               end else if (free_at >= 0) begin
                  slot_key_m[free_at]   = k;
                  slot_state_m[free_at] = SLOT_LIVE;
                  live_keys++;
                  ans.status     = STATUS_INSERTED;
                  ans.slot_index = free_at[SLOT_W-1:0];
               end else begin
                  ans.status = STATUS_FULL;
               end
            end
            REQ_LOOKUP: begin
               if (hit >= 0) begin
                  ans.status     = STATUS_FOUND;
                  ans.slot_index = hit[SLOT_W-1:0];
               end else begin
                  ans.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               if (hit >= 0) begin
                  slot_state_m[hit] = SLOT_TOMB;
                  if (live_keys > 0) live_keys--;
                  ans.status     = STATUS_REMOVED;
                  ans.slot_index = hit[SLOT_W-1:0];
               end else begin
                  ans.status = STATUS_NOT_FOUND;
               end
            end
         endcase
      end
      ans.live_count = live_keys[COUNT_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         foreach (slot_state_m[i]) slot_state_m[i] = SLOT_EMPTY;
         live_keys  = 0;
         fail_count = 0;
         awaited_rsp.delete();
      end else begin
         if (req_valid && !req_stall) awaited_rsp.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("unrequested result: status %0d, slot_index %0d, live_count %0d",
                      rsp_data.status, rsp_data.slot_index, rsp_data.live_count);
               fail_count = fail_count + 1;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, actual %0d",
                         want.slot_index, rsp_data.slot_index);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.live_count !== want.live_count) begin
                  $error("live_count: expected %0d, actual %0d",
                         want.live_count, rsp_data.live_count);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Bench top for the pointer hash set: clock, reset, request and result-side stall
// stimulus, and the verdict. Depends on phs_pkg, hash_set_checker and the block.
module tb;
   import phs_pkg::*;

   localparam int TABLE_SIZE    = 1021;
   localparam int KEY_WIDTH     = 64;
   localparam int POOL_N        = 40;
   localparam int SEGMENT_ITEMS = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 1100;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   int           fail_count;
   int           pending;
   int           send_idle_pct = 20;
   int           recv_idle_pct = 71;
   bit           hold_go  = 1'b0;
   bit           hold_rsp = 1'b0;
   logic [KEY_W-1:0] key_pool [POOL_N];

   always #1 clock = ~clock;

   pointer_hash_set_linear_probe_top #(
      .TABLE_SIZE(TABLE_SIZE),
      .KEY_WIDTH (KEY_WIDTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   hash_set_checker #(
      .TABLE_SIZE(TABLE_SIZE),
      .KEY_WIDTH (KEY_WIDTH)
   ) chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .fail_count(fail_count),
      .pending   (pending)
   );

   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // one long hold-off on the result side so the block backs up into its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #25_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the item is taken,
   // with valid still high so back-to-back items need no extra edge.
   task automatic send_req(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, k};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      wait_drained();
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      @(negedge clock);
   endtask

   // mostly pool keys so inserts, hits and removes interact; some null and fresh keys
   task automatic send_mixed_request();
      int               pick;
      logic [REQ_W-1:0] op;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(99);
      if (pick == 0) op = REQ_CLEAR;
      else if (pick < 46) op = REQ_INSERT;
      else if (pick < 75) op = REQ_LOOKUP;
      else op = REQ_REMOVE;
      pick = $urandom_range(99);
      if (pick < 3) k = '0;
      else if (pick < 12) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(POOL_N - 1)];
      send_req(op, k);
   endtask

   initial begin : stimulus
      // half the pool clusters around the wrap point of the table, half is wide keys
      for (int i = 0; i < POOL_N; i++) begin
         if (i % 2 == 0)
            key_pool[i] = KEY_W'(TABLE_SIZE * $urandom_range(4000000, 1)
                                 + ((1016 + $urandom_range(11)) % TABLE_SIZE));
         else
            key_pool[i] = {$urandom, $urandom} | 64'd1;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_req(REQ_LOOKUP, 64'd1);
      send_req(REQ_CLEAR, 64'd0);
      send_req(REQ_INSERT, 64'd0);
      send_req(REQ_LOOKUP, 64'd0);
      send_req(REQ_REMOVE, 64'd0);
      send_req(REQ_INSERT, 64'd1021);
      send_req(REQ_INSERT, 64'd2042);
      send_req(REQ_INSERT, 64'd1021);
      send_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(REQ_INSERT, 64'h8000_0000_0000_0000);
      send_req(REQ_INSERT, 64'd1020);
      send_req(REQ_INSERT, 64'd2041);    // wraps past the last slot
      send_req(REQ_REMOVE, 64'd1021);
      send_req(REQ_LOOKUP, 64'd2042);    // probe passes a tombstone
      send_req(REQ_LOOKUP, 64'd2041);
      send_req(REQ_REMOVE, 64'd1021);
      send_req(REQ_INSERT, 64'd3063);    // reuses the tombstone
      send_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(REQ_REMOVE, 64'h8000_0000_0000_0000);
      send_req(REQ_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(REQ_LOOKUP, 64'd2042);

      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
         if (i == 100) hold_go = 1'b1;
         if (i == 200) wait_drained();
         send_mixed_request();
      end
      set_idling(71, 20);
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_mixed_request();
      set_idling(0, 0);
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_mixed_request();

      // tombstone reuse across the wrap point
      send_req(REQ_CLEAR, {$urandom, $urandom});
      send_req(REQ_INSERT, 64'd1020);
      send_req(REQ_INSERT, 64'd2041);    // wraps to slot 0
      send_req(REQ_INSERT, 64'd3062);
      send_req(REQ_REMOVE, 64'd2041);
      send_req(REQ_LOOKUP, 64'd3062);    // passes the tombstone in slot 0
      send_req(REQ_INSERT, 64'd4083);    // takes slot 0 again
      send_req(REQ_INSERT, 64'd0);
      send_req(REQ_LOOKUP, 64'd5104);    // miss ends at the first empty slot
      send_req(REQ_REMOVE, 64'd3062);
      send_req(REQ_REMOVE, 64'd3062);
      send_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(REQ_CLEAR, 64'd0);
      send_req(REQ_LOOKUP, 64'd1);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/phs_pkg.sv
rtl/phs_ram.sv
rtl/phs_mod_unit.sv
rtl/pointer_hash_set_linear_probe_top.sv
bench/hash_set_checker.sv
bench/tb.sv
